// ----- sv/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// mse_pkg
// Shared codes, field widths and constants of the membership set engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int MSE_DEPTH = 1024;

  localparam int MODE_W = 3;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 8;
  localparam int CNT_W  = 11;

  localparam int IN_W  = 32;
  localparam int OUT_W = 48;

  localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FIND1  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_FIND2  = 3'd7;

  localparam logic [VAL_W-1:0] PLAIN_MEMBER = 8'd255;
  localparam logic [VAL_W-1:0] ADD_VALUE    = 8'd1;

  localparam logic signed [CNT_W-1:0] NONE_IDX = -11'sd1;

endpackage

// ----- sv/membership_set_engine.sv -----
// ----------------------------------------------------------------------------
// membership_set_engine
// Set of indices held as one byte per entry in an internal memory, walked by
// a small sequencer over a single read/write port.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one command transaction (mode, index, range end,
//   value); m_* channel returns one result transaction per command. The APB
//   port holds extended_mode at address 0; the user writes it only while
//   idle, which the block itself does not enforce. s_tready is high only
//   while the sequencer is idle; one command is worked on at a time, so a
//   new command is taken only once the last result is in the output register.
//   Per command (N = entries held, at most 1024): a query or empty range
//   reads the entry; an index error or a find first with a known first-added
//   member is reported directly; add/remove/toggle/write update each entry
//   of the range, then read the index, scanning down for a new highest member
//   if it was removed; clear all sweeps all N entries; find first/second scan
//   up from entry 0. After reset the store is swept to zero, one entry a cycle,
//   before the first command is taken; APB writes are taken meanwhile.
//   A finished result waits in the output register while m_tready is low;
//   the sequencer holds in its final step until the register frees.
// ----------------------------------------------------------------------------
module membership_set_engine #(
  parameter int NUM_ENTRIES = mse_pkg::MSE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // mode[2:0], index[12:3], range_end[22:13], value[30:23]
  input  logic [mse_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // is_member[0], entry_value[8:1], member_count[19:9], highest_member[30:20],
  // found_index[41:31], index_error[42]
  output logic [mse_pkg::OUT_W-1:0] m_tdata
);
  import mse_pkg::*;

  localparam int SPAN = (NUM_ENTRIES < MSE_DEPTH) ? NUM_ENTRIES : MSE_DEPTH;
  localparam int AW   = $clog2(SPAN);
  localparam logic [AW-1:0]    LAST_PTR = AW'(SPAN - 1);
  localparam logic [CNT_W-1:0] SPAN_W   = CNT_W'(SPAN);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_QRD   = 4'd2;
  localparam logic [3:0] S_QOUT  = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RUPD  = 4'd5;
  localparam logic [3:0] S_HRD   = 4'd6;
  localparam logic [3:0] S_HCHK  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] st, st_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] q_ptr, q_ptr_next;
  logic [AW-1:0] end_ptr, end_ptr_next;
  logic [MODE_W-1:0] op, op_next;
  logic [VAL_W-1:0] wval, wval_next;
  logic [CNT_W-1:0] count, count_next;
  logic signed [CNT_W-1:0] highest, highest_next;
  logic signed [CNT_W-1:0] first_added, first_added_next;
  logic need_scan, need_scan_next;
  logic one_hit, one_hit_next;
  logic clr_report, clr_report_next;
  logic ext_mode;
  logic res_member, res_member_next;
  logic [VAL_W-1:0] res_value, res_value_next;
  logic signed [CNT_W-1:0] res_found, res_found_next;
  logic res_err, res_err_next;
  logic m_tvalid_next;
  logic [OUT_W-1:0] m_tdata_next;

  logic [VAL_W-1:0] store [SPAN];
  logic [VAL_W-1:0] rdata;
  logic mem_we;
  logic [VAL_W-1:0] mem_wdata;

  logic [MODE_W-1:0] in_mode;
  logic [IDX_W-1:0] in_index, in_rend;
  logic [VAL_W-1:0] in_value;
  logic idx_oor, rend_oor, in_err;

  logic signed [CNT_W-1:0] ptr_s;
  logic is_mem, do_put, do_rm;
  logic [VAL_W-1:0] put_val;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, ext_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      ext_mode <= pwdata[0];
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[ptr] <= mem_wdata;
    end
    rdata <= store[ptr];
  end

  assign in_mode  = s_tdata[2:0];
  assign in_index = s_tdata[12:3];
  assign in_rend  = s_tdata[22:13];
  assign in_value = s_tdata[30:23];
  assign idx_oor  = {1'b0, in_index} >= SPAN_W;
  assign rend_oor = {1'b0, in_rend} >= SPAN_W;
  assign in_err   = (in_mode <= MODE_WRITE) &&
                    (idx_oor || ((in_mode >= MODE_ADD) && (in_mode <= MODE_TOGGLE) && rend_oor));

  assign s_tready = (st == S_IDLE);
  assign ptr_s    = CNT_W'(ptr);
  assign is_mem   = (rdata != '0);

  // per-entry update decision
  always_comb begin
    do_put  = 1'b0;
    do_rm   = 1'b0;
    put_val = ext_mode ? ADD_VALUE : PLAIN_MEMBER;
    unique case (op)
      MODE_ADD: begin
        do_put = ext_mode || !is_mem;
      end
      MODE_REMOVE: begin
        do_rm = is_mem;
      end
      MODE_TOGGLE: begin
        do_rm  = is_mem;
        do_put = !is_mem;
      end
      MODE_WRITE: begin
        if (ext_mode) begin
          if (wval == '0) begin
            do_rm = is_mem;
          end else begin
            do_put  = 1'b1;
            put_val = wval;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    st_next          = st;
    ptr_next         = ptr;
    q_ptr_next       = q_ptr;
    end_ptr_next     = end_ptr;
    op_next          = op;
    wval_next        = wval;
    count_next       = count;
    highest_next     = highest;
    first_added_next = first_added;
    need_scan_next   = need_scan;
    one_hit_next     = one_hit;
    clr_report_next  = clr_report;
    res_member_next  = res_member;
    res_value_next   = res_value;
    res_found_next   = res_found;
    res_err_next     = res_err;
    m_tvalid_next    = m_tvalid && !m_tready;
    m_tdata_next     = m_tdata;
    mem_we           = 1'b0;
    mem_wdata        = '0;

    unique case (st)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (ptr == LAST_PTR) begin
          count_next       = '0;
          highest_next     = NONE_IDX;
          first_added_next = NONE_IDX;
          clr_report_next  = 1'b0;
          st_next          = clr_report ? S_FIN : S_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      S_IDLE: begin
        if (s_tvalid) begin
          op_next         = in_mode;
          wval_next       = in_value;
          q_ptr_next      = in_index[AW-1:0];
          ptr_next        = in_index[AW-1:0];
          end_ptr_next    = (in_mode == MODE_WRITE) ? in_index[AW-1:0] : in_rend[AW-1:0];
          need_scan_next  = 1'b0;
          one_hit_next    = 1'b0;
          res_member_next = 1'b0;
          res_value_next  = '0;
          res_found_next  = NONE_IDX;
          res_err_next    = 1'b0;
          if (in_err) begin
            res_err_next = 1'b1;
            st_next      = S_FIN;
          end else begin
            unique case (in_mode)
              MODE_QUERY: begin
                st_next = S_QRD;
              end
              MODE_ADD, MODE_REMOVE, MODE_TOGGLE: begin
                st_next = (in_index > in_rend) ? S_QRD : S_RRD;
              end
              MODE_WRITE: begin
                st_next = S_RRD;
              end
              MODE_CLEAR: begin
                clr_report_next = 1'b1;
                ptr_next        = '0;
                st_next         = S_CLEAR;
              end
              MODE_FIND1: begin
                if (!first_added[CNT_W-1]) begin
                  res_found_next = first_added;
                  st_next        = S_FIN;
                end else begin
                  ptr_next = '0;
                  st_next  = S_FRD;
                end
              end
              MODE_FIND2: begin
                ptr_next = '0;
                st_next  = S_FRD;
              end
              default: begin
                st_next = S_FIN;
              end
            endcase
          end
        end
      end

      S_QRD: begin
        st_next = S_QOUT;
      end

      S_QOUT: begin
        res_member_next = is_mem;
        res_value_next  = ext_mode ? rdata : (is_mem ? PLAIN_MEMBER : '0);
        st_next         = S_FIN;
      end

      S_RRD: begin
        st_next = S_RUPD;
      end

      S_RUPD: begin
        if (do_put) begin
          mem_we    = 1'b1;
          mem_wdata = put_val;
          if (highest < ptr_s) begin
            highest_next   = ptr_s;
            need_scan_next = 1'b0;
          end
          if (first_added[CNT_W-1] && (count == '0)) begin
            first_added_next = ptr_s;
          end
          if (!is_mem) begin
            count_next = count + CNT_W'(1);
          end
        end else if (do_rm) begin
          mem_we     = 1'b1;
          mem_wdata  = '0;
          count_next = count - CNT_W'(1);
          if (highest == ptr_s) begin
            highest_next   = NONE_IDX;
            need_scan_next = 1'b1;
          end
          if (first_added == ptr_s) begin
            first_added_next = NONE_IDX;
          end
        end
        if (ptr == end_ptr) begin
          if (need_scan_next) begin
            need_scan_next = 1'b0;
            ptr_next       = LAST_PTR;
            st_next        = S_HRD;
          end else begin
            ptr_next = q_ptr;
            st_next  = S_QRD;
          end
        end else begin
          ptr_next = ptr + AW'(1);
          st_next  = S_RRD;
        end
      end

      S_HRD: begin
        st_next = S_HCHK;
      end

      S_HCHK: begin
        if (is_mem) begin
          highest_next = ptr_s;
          ptr_next     = q_ptr;
          st_next      = S_QRD;
        end else if (ptr == '0) begin
          ptr_next = q_ptr;
          st_next  = S_QRD;
        end else begin
          ptr_next = ptr - AW'(1);
          st_next  = S_HRD;
        end
      end

      S_FRD: begin
        st_next = S_FCHK;
      end

      S_FCHK: begin
        if (is_mem && (op == MODE_FIND1 || one_hit ||
                       (!first_added[CNT_W-1] && (ptr_s != first_added)))) begin
          res_found_next = ptr_s;
          st_next        = S_FIN;
        end else if (ptr == LAST_PTR) begin
          res_found_next = NONE_IDX;
          st_next        = S_FIN;
        end else begin
          if (is_mem) begin
            one_hit_next = 1'b1;
          end
          ptr_next = ptr + AW'(1);
          st_next  = S_FRD;
        end
      end

      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {5'd0, res_err, res_found, highest, count, res_value, res_member};
          st_next       = S_IDLE;
        end
      end

      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_CLEAR;
      ptr         <= '0;
      count       <= '0;
      highest     <= NONE_IDX;
      first_added <= NONE_IDX;
      need_scan   <= 1'b0;
      one_hit     <= 1'b0;
      clr_report  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      st          <= st_next;
      ptr         <= ptr_next;
      count       <= count_next;
      highest     <= highest_next;
      first_added <= first_added_next;
      need_scan   <= need_scan_next;
      one_hit     <= one_hit_next;
      clr_report  <= clr_report_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    q_ptr      <= q_ptr_next;
    end_ptr    <= end_ptr_next;
    op         <= op_next;
    wval       <= wval_next;
    res_member <= res_member_next;
    res_value  <= res_value_next;
    res_found  <= res_found_next;
    res_err    <= res_err_next;
    m_tdata    <= m_tdata_next;
  end

  // consistency of the bookkeeping registers and the command handshake
  assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> ((count == '0) == (highest == NONE_IDX)))
    else $error("member count and highest member disagree");

  assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> ((first_added == NONE_IDX) || (count != '0)))
    else $error("first added member set on an empty set");

  assert property (@(posedge clk) disable iff (rst)
    count <= SPAN_W)
    else $error("member count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (st != S_IDLE))
    else $error("accepted transaction did not start the sequencer");

endmodule
